// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; each expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AATD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define AATD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aatd_pkg.sv =====
package aatd_pkg;

  // Default sizing of the top level.
  localparam int MAX_OUT_DIM_DEF = 64;
  localparam int MAX_SRC_DIM_DEF = 1024;

  // Fixed field and register widths.
  localparam int PIX_W      = 8;
  localparam int SRC_DIM_W  = 11;
  localparam int OUT_DIM_W  = 7;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_COMP   = 3;
  localparam int QUO_W      = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;

  // Reset value of every dimension register.
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 11'd64;

  // Component lanes in the divider.
  localparam int LANE_BLUE  = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_RED   = 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_ERD,
    S_ELD,
    S_DIV
  } state_e;

  // Status of the source position for the pixel being taken.
  typedef struct packed {
    logic row_emit;
    logic tile_last;
  } pos_stat_t;

endpackage

// ===== rtl/aatd_acc_mem.sv =====
module aatd_acc_mem import aatd_pkg::*; #(
  parameter int DEPTH   = MAX_OUT_DIM_DEF,
  parameter int ENTRY_W = 105
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_all_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [ENTRY_W-1:0]       rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [ENTRY_W-1:0]       wr_data_i,
  input  logic                     inv_en_i,
  input  logic [$clog2(DEPTH)-1:0] inv_addr_i
);

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [DEPTH-1:0]   vld_q;
  logic               rd_vld_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Track which entries hold data since the last clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_all_i) begin
        vld_q <= '0;
      end else begin
        if (wr_en_i) begin
          vld_q[wr_addr_i] <= 1'b1;
        end
        if (inv_en_i) begin
          vld_q[inv_addr_i] <= 1'b0;
        end
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // An entry that is not valid reads as zero.
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/aatd_div.sv =====
module aatd_div import aatd_pkg::*; #(
  parameter int SUM_W = 28,
  parameter int CNT_W = 21
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [NUM_COMP-1:0][SUM_W-1:0]     sum_i,
  input  logic [CNT_W-1:0]                   cnt_i,
  output logic                               done_o,
  output logic [NUM_COMP-1:0][QUO_W-1:0]     quo_o
);

  localparam int STEP_W = $clog2(QUO_W);

  logic [NUM_COMP-1:0][SUM_W-1:0] rem_q, rem_d;
  logic [NUM_COMP-1:0][QUO_W-1:0] quo_q, quo_d;
  logic [SUM_W-1:0]               dvs_q, dvs_d;
  logic [STEP_W-1:0]              step_q, step_d;
  logic                           busy_q, busy_d;
  logic                           zero_q, zero_d;

  // One restoring step per cycle, the three components side by side.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    zero_d = zero_q;
    if (start_i) begin
      rem_d  = sum_i;
      quo_d  = '0;
      dvs_d  = SUM_W'(cnt_i) << (QUO_W - 1);
      step_d = '0;
      busy_d = 1'b1;
      zero_d = (cnt_i == '0);
    end else if (busy_q) begin
      for (int l = 0; l < NUM_COMP; l++) begin
        if (rem_q[l] >= dvs_q) begin
          rem_d[l] = rem_q[l] - dvs_q;
          quo_d[l] = {quo_q[l][QUO_W-2:0], 1'b1};
        end else begin
          quo_d[l] = {quo_q[l][QUO_W-2:0], 1'b0};
        end
      end
      dvs_d  = dvs_q >> 1;
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    zero_q <= zero_d;
  end

  // An empty window averages to zero.
  assign done_o = !busy_q;
  assign quo_o  = zero_q ? '0 : quo_q;

endmodule

// ===== rtl/aatd_pos.sv =====
module aatd_pos import aatd_pkg::*; #(
  parameter int MAX_OUT_DIM = MAX_OUT_DIM_DEF,
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 restart_i,
  input  logic                                 adv_i,
  input  logic [$clog2(MAX_SRC_DIM+1)-1:0]     sw_i,
  input  logic [$clog2(MAX_SRC_DIM+1)-1:0]     sh_i,
  input  logic [$clog2(MAX_OUT_DIM+1)-1:0]     ow_i,
  input  logic [$clog2(MAX_OUT_DIM+1)-1:0]     oh_i,
  output logic [$clog2(MAX_OUT_DIM)-1:0]       win_idx_o,
  output pos_stat_t                            stat_o
);

  localparam int SRC_IDX_W = $clog2(MAX_SRC_DIM);
  localparam int OUT_IDX_W = $clog2(MAX_OUT_DIM);
  localparam int SW_W      = $clog2(MAX_SRC_DIM + 1);
  localparam int OW_W      = $clog2(MAX_OUT_DIM + 1);
  localparam int PROD_W    = SRC_IDX_W + OUT_IDX_W + 3;

  // a: x*sw, b: col*ow, c: orow*sh, d: row*oh
  logic [SRC_IDX_W-1:0] col_q, col_d, row_q, row_d;
  logic [OUT_IDX_W-1:0] orow_q, orow_d, x_q, x_d;
  logic [PROD_W-1:0]    a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;

  logic [PROD_W-1:0] sw_p, sh_p, ow_p, oh_p, b_n;
  logic              col_last, row_last, orow_last, x_adv, emit;

  // Window boundaries compared as cross products.
  always_comb begin
    sw_p      = PROD_W'(sw_i);
    sh_p      = PROD_W'(sh_i);
    ow_p      = PROD_W'(ow_i);
    oh_p      = PROD_W'(oh_i);
    col_last  = (SW_W'(col_q) + SW_W'(1)) >= sw_i;
    row_last  = (SW_W'(row_q) + SW_W'(1)) >= sh_i;
    orow_last = (OW_W'(orow_q) + OW_W'(1)) >= oh_i;
    b_n       = b_q + ow_p;
    x_adv     = ((OW_W'(x_q) + OW_W'(1)) < ow_i) && ((a_q + sw_p) < (b_n + ow_p));
    emit      = col_last && ((d_q + oh_p) <= (c_q + sh_p))
                && ((c_q + sh_p) < (d_q + oh_p + oh_p));
  end

  // Advance the raster position by one pixel.
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    orow_d = orow_q;
    x_d    = x_q;
    a_d    = a_q;
    b_d    = b_q;
    c_d    = c_q;
    d_d    = d_q;
    if (restart_i) begin
      col_d  = '0;
      row_d  = '0;
      orow_d = '0;
      x_d    = '0;
      a_d    = '0;
      b_d    = '0;
      c_d    = '0;
      d_d    = '0;
    end else if (adv_i) begin
      if (col_last) begin
        col_d = '0;
        x_d   = '0;
        a_d   = '0;
        b_d   = '0;
        if (emit) begin
          orow_d = orow_last ? '0 : orow_q + OUT_IDX_W'(1);
          c_d    = orow_last ? '0 : c_q + sh_p;
        end
        if (row_last) begin
          row_d  = '0;
          d_d    = '0;
          orow_d = '0;
          c_d    = '0;
        end else begin
          row_d = row_q + SRC_IDX_W'(1);
          d_d   = d_q + oh_p;
        end
      end else begin
        col_d = col_q + SRC_IDX_W'(1);
        b_d   = b_n;
        if (x_adv) begin
          x_d = x_q + OUT_IDX_W'(1);
          a_d = a_q + sw_p;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      orow_q <= '0;
      x_q    <= '0;
      a_q    <= '0;
      b_q    <= '0;
      c_q    <= '0;
      d_q    <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      orow_q <= orow_d;
      x_q    <= x_d;
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
      d_q    <= d_d;
    end
  end

  assign win_idx_o        = x_q;
  assign stat_o.row_emit  = emit;
  assign stat_o.tile_last = orow_last;

endmodule

// ===== rtl/area_average_tile_downscaler_unit.sv =====
// Channel   Direction  Handshake                 Beat
// pixel     in         in_valid_i / in_stall_o   blue, green, red, inside flag
// result    out        out_valid_o / out_stall_i blue, green, red, row and tile end
// config    in         cfg_we_i                  register index and data
//
// A pixel beat is accepted with the accumulator read, then written back while
// the input stalls. Each result of a completed output row takes a read, a load,
// 8 divide steps in the shared divider and an output load; the input stalls.
// Reset clears the accumulator valid bits at once, so no clearing pass runs.
// A pixel is accepted while the last result of a row waits at the output.
`include "assert_macros.svh"

module area_average_tile_downscaler_unit import aatd_pkg::*; #(
  parameter int MAX_OUT_DIM = MAX_OUT_DIM_DEF,
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      in_blue_i,
  input  logic [PIX_W-1:0]      in_green_i,
  input  logic [PIX_W-1:0]      in_red_i,
  input  logic                  inside_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      out_blue_o,
  output logic [PIX_W-1:0]      out_green_o,
  output logic [PIX_W-1:0]      out_red_o,
  output logic                  row_end_o,
  output logic                  tile_end_o
);

  localparam int OUT_IDX_W = $clog2(MAX_OUT_DIM);
  localparam int SRC_IDX_W = $clog2(MAX_SRC_DIM);
  localparam int SW_W      = $clog2(MAX_SRC_DIM + 1);
  localparam int OW_W      = $clog2(MAX_OUT_DIM + 1);
  localparam int CNT_W     = 2 * SRC_IDX_W + 1;
  localparam int SUM_W     = CNT_W + QUO_W - 1;
  localparam int ENTRY_W   = NUM_COMP * SUM_W + CNT_W;

  state_e state_q, state_d;

  logic [SRC_DIM_W-1:0] cfg_sw_q, cfg_sh_q;
  logic [OUT_DIM_W-1:0] cfg_ow_q, cfg_oh_q;
  logic [SW_W-1:0]      eff_sw, eff_sh;
  logic [OW_W-1:0]      ow_c, oh_c, eff_ow, eff_oh;
  logic                 restart;

  logic                 in_acc;
  logic [OUT_IDX_W-1:0] win_idx;
  pos_stat_t            pos_stat;

  logic [PIX_W-1:0]     pix_b_q, pix_g_q, pix_r_q;
  logic                 pix_in_q;
  logic [OUT_IDX_W-1:0] pix_idx_q;
  logic                 emit_q, last_row_q;
  logic [OUT_IDX_W-1:0] k_q;
  logic                 k_last;

  logic                 mem_rd_en, mem_wr_en, mem_inv_en;
  logic [OUT_IDX_W-1:0] mem_rd_addr;
  logic [ENTRY_W-1:0]   mem_rd_data, mem_wr_data;
  logic [SUM_W-1:0]     acc_b, acc_g, acc_r;
  logic [CNT_W-1:0]     acc_cnt;

  logic                               div_start, div_done;
  logic [NUM_COMP-1:0][SUM_W-1:0]     div_sum;
  logic [NUM_COMP-1:0][QUO_W-1:0]     div_quo;
  logic                               out_load;
  logic                               out_valid_q;

  // Configuration registers; any known write restarts the tile.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sw_q <= DIM_RESET;
      cfg_sh_q <= DIM_RESET;
      cfg_ow_q <= DIM_RESET[OUT_DIM_W-1:0];
      cfg_oh_q <= DIM_RESET[OUT_DIM_W-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH:  cfg_sw_q <= cfg_data_i;
        REG_SRC_HEIGHT: cfg_sh_q <= cfg_data_i;
        REG_OUT_WIDTH:  cfg_ow_q <= cfg_data_i[OUT_DIM_W-1:0];
        REG_OUT_HEIGHT: cfg_oh_q <= cfg_data_i[OUT_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i inside {REG_SRC_WIDTH, REG_SRC_HEIGHT,
                                                  REG_OUT_WIDTH, REG_OUT_HEIGHT});

  // Clamp dimensions: zero acts as one, no upscaling, no oversize.
  always_comb begin
    if (cfg_sw_q == '0) eff_sw = SW_W'(1);
    else if (32'(cfg_sw_q) > 32'(MAX_SRC_DIM)) eff_sw = SW_W'(MAX_SRC_DIM);
    else eff_sw = SW_W'(cfg_sw_q);
    if (cfg_sh_q == '0) eff_sh = SW_W'(1);
    else if (32'(cfg_sh_q) > 32'(MAX_SRC_DIM)) eff_sh = SW_W'(MAX_SRC_DIM);
    else eff_sh = SW_W'(cfg_sh_q);
    if (cfg_ow_q == '0) ow_c = OW_W'(1);
    else if (32'(cfg_ow_q) > 32'(MAX_OUT_DIM)) ow_c = OW_W'(MAX_OUT_DIM);
    else ow_c = OW_W'(cfg_ow_q);
    if (cfg_oh_q == '0) oh_c = OW_W'(1);
    else if (32'(cfg_oh_q) > 32'(MAX_OUT_DIM)) oh_c = OW_W'(MAX_OUT_DIM);
    else oh_c = OW_W'(cfg_oh_q);
    eff_ow = (32'(ow_c) > 32'(eff_sw)) ? OW_W'(eff_sw) : ow_c;
    eff_oh = (32'(oh_c) > 32'(eff_sh)) ? OW_W'(eff_sh) : oh_c;
  end

  assign in_acc = in_valid_i && !in_stall_o;
  assign k_last = (OW_W'(k_q) + OW_W'(1)) == eff_ow;

  aatd_pos #(
    .MAX_OUT_DIM(MAX_OUT_DIM),
    .MAX_SRC_DIM(MAX_SRC_DIM)
  ) u_pos (
    .clk_i,
    .rst_ni,
    .restart_i(restart),
    .adv_i    (in_acc),
    .sw_i     (eff_sw),
    .sh_i     (eff_sh),
    .ow_i     (eff_ow),
    .oh_i     (eff_oh),
    .win_idx_o(win_idx),
    .stat_o   (pos_stat)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_UPD;
      S_UPD:  state_d = emit_q ? S_ERD : S_IDLE;
      S_ERD:  state_d = S_ELD;
      S_ELD:  state_d = S_DIV;
      S_DIV:  if (out_load) state_d = k_last ? S_IDLE : S_ERD;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall_o  = 1'b1;
    mem_rd_en   = 1'b0;
    mem_rd_addr = win_idx;
    mem_wr_en   = 1'b0;
    mem_inv_en  = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        mem_rd_en  = in_valid_i;
      end
      S_UPD:  mem_wr_en = pix_in_q;
      S_ERD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = k_q;
      end
      S_ELD: begin
        div_start  = 1'b1;
        mem_inv_en = 1'b1;
      end
      S_DIV:  out_load = div_done && (!out_valid_q || !out_stall_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_UPD) begin
        k_q <= '0;
      end else if (out_load) begin
        k_q <= k_q + OUT_IDX_W'(1);
      end
    end
  end

  // Hold the accepted pixel and its window for the write back.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_b_q    <= in_blue_i;
      pix_g_q    <= in_green_i;
      pix_r_q    <= in_red_i;
      pix_in_q   <= inside_req_i;
      pix_idx_q  <= win_idx;
      emit_q     <= pos_stat.row_emit;
      last_row_q <= pos_stat.tile_last;
    end
  end

  // Unpack the accumulator entry and add the pixel.
  assign acc_b   = mem_rd_data[CNT_W+3*SUM_W-1:CNT_W+2*SUM_W];
  assign acc_g   = mem_rd_data[CNT_W+2*SUM_W-1:CNT_W+SUM_W];
  assign acc_r   = mem_rd_data[CNT_W+SUM_W-1:CNT_W];
  assign acc_cnt = mem_rd_data[CNT_W-1:0];

  assign mem_wr_data = {acc_b + SUM_W'(pix_b_q), acc_g + SUM_W'(pix_g_q),
                        acc_r + SUM_W'(pix_r_q), acc_cnt + CNT_W'(1)};

  aatd_acc_mem #(
    .DEPTH  (MAX_OUT_DIM),
    .ENTRY_W(ENTRY_W)
  ) u_mem (
    .clk_i,
    .rst_ni,
    .clr_all_i (restart),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (pix_idx_q),
    .wr_data_i (mem_wr_data),
    .inv_en_i  (mem_inv_en),
    .inv_addr_i(k_q)
  );

  assign div_sum[LANE_BLUE]  = acc_b;
  assign div_sum[LANE_GREEN] = acc_g;
  assign div_sum[LANE_RED]   = acc_r;

  aatd_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i(div_start),
    .sum_i  (div_sum),
    .cnt_i  (acc_cnt),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Output register: load a finished average, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_blue_o  <= div_quo[LANE_BLUE];
      out_green_o <= div_quo[LANE_GREEN];
      out_red_o   <= div_quo[LANE_RED];
      row_end_o   <= k_last;
      tile_end_o  <= k_last && last_row_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `AATD_ASSERT_NXT(a_acc_then_upd, in_acc, state_q == S_UPD, "pixel beat not written back")
  `AATD_ASSERT_NXT(a_emit_starts, (state_q == S_UPD) && emit_q, state_q == S_ERD,
                   "row emission did not start")
  `AATD_ASSERT_IMP(a_idx_range, (state_q == S_ERD) || (state_q == S_ELD) || (state_q == S_DIV),
                   OW_W'(k_q) < eff_ow, "emission index past output width")
  `AATD_ASSERT_IMP(a_tile_row, out_valid_o && tile_end_o, row_end_o,
                   "tile end without row end")

endmodule

// ===== tb/aatd_average_checker.sv =====
module aatd_average_checker import aatd_pkg::*; #(
  parameter int MAX_OUT_DIM = MAX_OUT_DIM_DEF,
  parameter int MAX_SRC_DIM = MAX_SRC_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  pix_valid_i,
  input  logic                  pix_stall_i,
  input  logic [PIX_W-1:0]      pix_blue_i,
  input  logic [PIX_W-1:0]      pix_green_i,
  input  logic [PIX_W-1:0]      pix_red_i,
  input  logic                  pix_inside_i,
  input  logic                  res_valid_i,
  input  logic                  res_stall_i,
  input  logic [PIX_W-1:0]      res_blue_i,
  input  logic [PIX_W-1:0]      res_green_i,
  input  logic [PIX_W-1:0]      res_red_i,
  input  logic                  res_row_end_i,
  input  logic                  res_tile_end_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           pixel_beats_o,
  output int unsigned           result_beats_o
);

  // Cap on mismatch lines so a broken build does not flood the log.
  localparam int unsigned MSG_CAP = 40;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             row_end;
    logic             tile_end;
  } avg_px_t;

  avg_px_t expected_px[$];

  // Shadow copy of the dimension registers
  logic [SRC_DIM_W-1:0] src_width_q;
  logic [SRC_DIM_W-1:0] src_height_q;
  logic [OUT_DIM_W-1:0] out_width_q;
  logic [OUT_DIM_W-1:0] out_height_q;

  // Per-column window accumulators and raster position
  int unsigned acc_blue[MAX_OUT_DIM];
  int unsigned acc_green[MAX_OUT_DIM];
  int unsigned acc_red[MAX_OUT_DIM];
  int unsigned acc_count[MAX_OUT_DIM];
  int unsigned src_col;
  int unsigned src_row;
  int unsigned out_row;

  // Zero acts as one, oversized values saturate.
  function automatic int unsigned fit_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic void clear_tile();
    for (int k = 0; k < MAX_OUT_DIM; k++) begin
      acc_blue[k]  = 0;
      acc_green[k] = 0;
      acc_red[k]   = 0;
      acc_count[k] = 0;
    end
    src_col = 0;
    src_row = 0;
    out_row = 0;
  endfunction

  // Add one source pixel to its column window; queue a full output row when
  // the last source pixel of that output row arrives.
  function automatic void accumulate_pixel(input logic [PIX_W-1:0] b, g, r,
                                           input logic counted);
    int unsigned sw, sh, ow, oh, col, row, x;
    logic last_row;
    avg_px_t px;
    sw = fit_dim(src_width_q, MAX_SRC_DIM);
    sh = fit_dim(src_height_q, MAX_SRC_DIM);
    ow = fit_dim(out_width_q, MAX_OUT_DIM);
    oh = fit_dim(out_height_q, MAX_OUT_DIM);
    if (ow > sw) ow = sw;
    if (oh > sh) oh = sh;
    if (src_col >= sw || src_row >= sh || out_row >= oh) clear_tile();
    col = src_col;
    row = src_row;
    x = 0;
    while (x + 1 < ow && ((x + 1) * sw) / ow <= col) x++;
    if (counted) begin
      acc_blue[x]  += b;
      acc_green[x] += g;
      acc_red[x]   += r;
      acc_count[x] += 1;
    end
    if (col + 1 >= sw) begin
      if (row + 1 == ((out_row + 1) * sh) / oh) begin
        last_row = (out_row + 1 >= oh);
        for (int k = 0; k < ow; k++) begin
          px.blue     = acc_count[k] != 0 ? PIX_W'(acc_blue[k] / acc_count[k]) : '0;
          px.green    = acc_count[k] != 0 ? PIX_W'(acc_green[k] / acc_count[k]) : '0;
          px.red      = acc_count[k] != 0 ? PIX_W'(acc_red[k] / acc_count[k]) : '0;
          px.row_end  = (k + 1 == ow);
          px.tile_end = (k + 1 == ow) && last_row;
          expected_px.push_back(px);
          acc_blue[k]  = 0;
          acc_green[k] = 0;
          acc_red[k]   = 0;
          acc_count[k] = 0;
        end
        out_row = last_row ? 0 : out_row + 1;
      end
      src_col = 0;
      if (row + 1 >= sh) begin
        src_row = 0;
        out_row = 0;
      end else begin
        src_row = row + 1;
      end
    end else begin
      src_col = col + 1;
    end
  endfunction

  function automatic void check_field(input string name, input logic [PIX_W-1:0] want,
                                      input logic [PIX_W-1:0] got);
    if (want !== got) begin
      fail_count_o++;
      if (fail_count_o <= MSG_CAP)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Track register writes, predict on pixel beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin
    avg_px_t want;
    if (!rst_ni) begin
      src_width_q    = DIM_RESET;
      src_height_q   = DIM_RESET;
      out_width_q    = DIM_RESET[OUT_DIM_W-1:0];
      out_height_q   = DIM_RESET[OUT_DIM_W-1:0];
      clear_tile();
      expected_px.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      pixel_beats_o  = 0;
      result_beats_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH: begin
            src_width_q = cfg_data_i;
            clear_tile();
          end
          REG_SRC_HEIGHT: begin
            src_height_q = cfg_data_i;
            clear_tile();
          end
          REG_OUT_WIDTH: begin
            out_width_q = cfg_data_i[OUT_DIM_W-1:0];
            clear_tile();
          end
          REG_OUT_HEIGHT: begin
            out_height_q = cfg_data_i[OUT_DIM_W-1:0];
            clear_tile();
          end
          default: ;
        endcase
      end
      if (pix_valid_i && !pix_stall_i) begin
        accumulate_pixel(pix_blue_i, pix_green_i, pix_red_i, pix_inside_i);
        pixel_beats_o++;
      end
      if (res_valid_i && !res_stall_i) begin
        result_beats_o++;
        if (expected_px.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MSG_CAP)
            $display("%0t: result beat with nothing expected: actual b %0d g %0d r %0d",
                     $time, res_blue_i, res_green_i, res_red_i);
        end else begin
          want = expected_px.pop_front();
          check_field("blue", want.blue, res_blue_i);
          check_field("green", want.green, res_green_i);
          check_field("red", want.red, res_red_i);
          check_field("row_end", want.row_end, res_row_end_i);
          check_field("tile_end", want.tile_end, res_tile_end_i);
        end
      end
      pending_o = expected_px.size();
    end
  end

endmodule

// ===== tb/tb_area_average_tile_downscaler_unit.sv =====
module tb_area_average_tile_downscaler_unit;
  import aatd_pkg::*;

  // Index outside the register map; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam int RANDOM_PIXELS = 180;
  localparam int MIN_PHASES    = 4;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int BIG_DIM       = 2047;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic [PIX_W-1:0]      in_blue_i    = '0;
  logic [PIX_W-1:0]      in_green_i   = '0;
  logic [PIX_W-1:0]      in_red_i     = '0;
  logic                  inside_req_i = 1'b0;
  logic                  out_stall_i  = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [PIX_W-1:0]      out_blue_o;
  logic [PIX_W-1:0]      out_green_o;
  logic [PIX_W-1:0]      out_red_o;
  logic                  row_end_o;
  logic                  tile_end_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned pixel_beats;
  int unsigned result_beats;
  int unsigned gap_pct       = 0;
  int unsigned stall_pct     = 0;
  int unsigned settings_seen = 0;
  logic        hold_req      = 1'b0;

  area_average_tile_downscaler_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_blue_i    (in_blue_i),
    .in_green_i   (in_green_i),
    .in_red_i     (in_red_i),
    .inside_req_i (inside_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_blue_o   (out_blue_o),
    .out_green_o  (out_green_o),
    .out_red_o    (out_red_o),
    .row_end_o    (row_end_o),
    .tile_end_o   (tile_end_o)
  );

  aatd_average_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pix_valid_i    (in_valid_i),
    .pix_stall_i    (in_stall_o),
    .pix_blue_i     (in_blue_i),
    .pix_green_i    (in_green_i),
    .pix_red_i      (in_red_i),
    .pix_inside_i   (inside_req_i),
    .res_valid_i    (out_valid_o),
    .res_stall_i    (out_stall_i),
    .res_blue_i     (out_blue_o),
    .res_green_i    (out_green_o),
    .res_red_i      (out_red_o),
    .res_row_end_i  (row_end_o),
    .res_tile_end_i (tile_end_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .pixel_beats_o  (pixel_beats),
    .result_beats_o (result_beats)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: random stall, or a long hold-off when requested
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall_i <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
    end
    out_stall_i <= ($urandom_range(99, 0) < stall_pct);
  end

  // Bound the run
  initial begin
    #30_000_000;
    $display("area_average_tile_downscaler_unit verification failed");
    $finish;
  end

  task automatic set_mode(input int m);
    case (m)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 47; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 47; end
      default: begin gap_pct = 25; stall_pct = 25; end
    endcase
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_dims(input int unsigned sw, sh, ow, oh);
    cfg_write(REG_SRC_WIDTH, sw);
    cfg_write(REG_SRC_HEIGHT, sh);
    cfg_write(REG_OUT_WIDTH, ow);
    cfg_write(REG_OUT_HEIGHT, oh);
    settings_seen++;
  endtask

  // Offer one pixel beat and hold it until taken; valid stays up afterwards.
  task automatic send_pixel(input logic [PIX_W-1:0] b, g, r, input logic counted);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_blue_i    <= b;
    in_green_i   <= g;
    in_red_i     <= r;
    inside_req_i <= counted;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Bias toward the component extremes now and then.
  function automatic logic [PIX_W-1:0] pick_component();
    int unsigned sel;
    sel = $urandom_range(7, 0);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return PIX_W'($urandom_range(255, 0));
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_pixel(pick_component(), pick_component(), pick_component(),
                 $urandom_range(99, 0) < 85);
  endtask

  // Drop valid, wait out every expected result, then let the block settle.
  task automatic drain(input int settle);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  initial begin
    int unsigned sw, sh, ow, oh, n, random_done, phase;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Two by two output over a 4x2 source: full-scale values, truncation,
    // an all-skipped row giving zeros, then wrap into a second tile.
    set_mode(0);
    set_dims(4, 2, 2, 2);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd254, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd1, 8'd0, 8'd255, 1'b1);
    repeat (4) send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
    send_pixel(8'd7, 8'd8, 8'd9, 1'b1);
    send_pixel(8'd3, 8'd4, 8'd5, 1'b0);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b1);
    drain(SETTLE_CYCLES);

    // Write to an unmapped index mid-tile; the tile must carry on.
    cfg_write(REG_UNUSED, 11'h7FF);
    send_pixel(8'd170, 8'd85, 8'd255, 1'b1);
    send_pixel(8'd85, 8'd170, 8'd0, 1'b1);
    send_pixel(8'd128, 8'd127, 8'd64, 1'b1);
    send_pixel(8'd129, 8'd128, 8'd63, 1'b0);
    drain(SETTLE_CYCLES);

    // All dimensions zero: every pixel is a whole tile.
    set_dims(0, 0, 0, 0);
    send_pixel(8'd42, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd42, 1'b0);
    send_pixel(8'd255, 8'd1, 8'd2, 1'b1);
    drain(SETTLE_CYCLES);

    // Output larger than source, with masked upper bits in the output writes.
    set_dims(3, 2, 11'h7FF, 11'h440);
    send_random(6);
    drain(SETTLE_CYCLES);

    // Hold the result side off while a wide tile streams in.
    set_dims(64, 2, 64, 2);
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    send_random(128);
    drain(SETTLE_CYCLES);

    // Oversized source height on a one-column tile: four output rows.
    set_mode(2);
    set_dims(1, BIG_DIM, 1, 64);
    send_random(64);
    drain(SETTLE_CYCLES);

    // Random small tiles, rotating through the idle and stall patterns.
    random_done = 0;
    phase = 0;
    while (random_done < RANDOM_PIXELS || phase < MIN_PHASES) begin
      set_mode(phase % 4);
      if ($urandom_range(3, 0) == 0) cfg_write(REG_UNUSED, $urandom_range(2047, 0));
      sw = $urandom_range(12, 0);
      sh = $urandom_range(6, 0);
      ow = $urandom_range(sw + 3, 0) | ($urandom_range(15, 0) << OUT_DIM_W);
      oh = $urandom_range(sh + 2, 0) | ($urandom_range(15, 0) << OUT_DIM_W);
      set_dims(sw, sh, ow, oh);
      n = (sw + 1) * (sh + 1) * $urandom_range(2, 1) + $urandom_range(sw, 0);
      if (phase == 2) begin
        // Pause the sender until everything so far has come out.
        send_random(n / 2);
        drain(0);
        send_random(n - n / 2);
      end else begin
        send_random(n);
      end
      drain(SETTLE_CYCLES);
      random_done += n;
      phase++;
    end

    drain(SETTLE_CYCLES * 4);
    $display("Covered %0d pixel beats and %0d averaged output beats over %0d settings.",
             pixel_beats, result_beats, settings_seen);
    $display("Included empty, clamped and upscaling windows, tile wrap, ignored writes, %s",
             "a long output hold-off and a mid-stream drain.");
    if (fail_count == 0)
      $display("area_average_tile_downscaler_unit verification clean");
    else
      $display("area_average_tile_downscaler_unit verification failed");
    $finish;
  end

endmodule
